[hw/rtl/lsse_pkg.sv]
// Package with item types, register codes and reset values for the LED strip symbol encoder.
`default_nettype none

package lsse_pkg;

  localparam int unsigned SYMBOL_BITS   = 10;
  localparam int unsigned BYTE_BITS     = 8;
  localparam int unsigned WORD_BITS     = 16;
  localparam int unsigned GAP_BITS      = 7;
  localparam int unsigned BYTE_WORDS    = 5;
  localparam int unsigned MAX_GAP_WORDS = 64;
  localparam int unsigned CFG_IDX_BITS  = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_ONE_PATTERN  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ZERO_PATTERN = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GAP_WORDS    = 2'd2;

  localparam logic [SYMBOL_BITS-1:0] ONE_PATTERN_RST  = 10'h3E0;
  localparam logic [SYMBOL_BITS-1:0] ZERO_PATTERN_RST = 10'h380;
  localparam logic [GAP_BITS-1:0]    GAP_WORDS_RST    = 7'd40;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_GAP  = 1'b1;

  typedef struct packed {
    logic                 command;
    logic [BYTE_BITS-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] line_word;
    logic                 last_word;
  } out_item_t;

  typedef struct packed {
    logic [SYMBOL_BITS-1:0] one_pattern;
    logic [SYMBOL_BITS-1:0] zero_pattern;
    logic [GAP_BITS-1:0]    gap_words;
  } cfg_t;

endpackage

`default_nettype wire

[hw/rtl/lsse_cfg_regs.sv]
// Configuration registers for the LED strip symbol encoder.
`default_nettype none

module lsse_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [lsse_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [lsse_pkg::SYMBOL_BITS-1:0]    cfg_wdata,
  output lsse_pkg::cfg_t                           cfg
);

  lsse_pkg::cfg_t cfg_r;
  lsse_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        lsse_pkg::CFG_ONE_PATTERN:  cfg_nxt.one_pattern  = cfg_wdata;
        lsse_pkg::CFG_ZERO_PATTERN: cfg_nxt.zero_pattern = cfg_wdata;
        lsse_pkg::CFG_GAP_WORDS:    cfg_nxt.gap_words    = cfg_wdata[lsse_pkg::GAP_BITS-1:0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.one_pattern  <= lsse_pkg::ONE_PATTERN_RST;
      cfg_r.zero_pattern <= lsse_pkg::ZERO_PATTERN_RST;
      cfg_r.gap_words    <= lsse_pkg::GAP_WORDS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[hw/rtl/lsse_word_gen.sv]
// Item register, word counter and symbol word selection for the LED strip symbol encoder.
`default_nettype none

module lsse_word_gen #(
  parameter int unsigned MAX_GAP_WORDS = lsse_pkg::MAX_GAP_WORDS
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire lsse_pkg::cfg_t     cfg,
  input  wire logic          in_valid,
  input  wire lsse_pkg::in_item_t in_item,
  output logic               in_stall,
  input  wire logic          load_en,
  output logic               word_valid,
  output lsse_pkg::out_item_t word
);

  localparam int unsigned CNT_RAW = $clog2(MAX_GAP_WORDS + 1);
  localparam int unsigned CW      = (CNT_RAW > 3) ? CNT_RAW : 3;
  localparam int unsigned STREAM  = lsse_pkg::BYTE_BITS * lsse_pkg::SYMBOL_BITS;

  logic                          a_valid_r, a_valid_nxt;
  logic                          a_cmd_r;
  logic [lsse_pkg::BYTE_BITS-1:0] a_data_r;
  logic [CW-1:0]                 a_idx_r, a_idx_nxt;

  logic [lsse_pkg::GAP_BITS-1:0] gap_sat;
  logic [CW-1:0]                 gap_n;
  logic [CW-1:0]                 total;
  logic                          a_last;
  logic                          take;
  logic                          issue;
  logic                          keep_item;
  logic [STREAM-1:0]             stream;
  logic [lsse_pkg::WORD_BITS-1:0] data_word;

  assign gap_sat = (cfg.gap_words > lsse_pkg::GAP_BITS'(MAX_GAP_WORDS))
                   ? lsse_pkg::GAP_BITS'(MAX_GAP_WORDS) : cfg.gap_words;
  assign gap_n   = CW'(gap_sat);
  assign total   = (a_cmd_r == lsse_pkg::CMD_GAP) ? gap_n : CW'(lsse_pkg::BYTE_WORDS);
  assign a_last  = (a_idx_r == (total - CW'(1)));

  assign issue     = a_valid_r && load_en;
  assign in_stall  = a_valid_r && !(load_en && a_last);
  assign take      = in_valid && !in_stall;
  assign keep_item = (in_item.command == lsse_pkg::CMD_DATA) || (gap_n != '0);

  always_comb begin
    for (int b = 0; b < lsse_pkg::BYTE_BITS; b++) begin
      stream[b*lsse_pkg::SYMBOL_BITS +: lsse_pkg::SYMBOL_BITS] =
        a_data_r[b] ? cfg.one_pattern : cfg.zero_pattern;
    end
  end

  always_comb begin
    case (a_idx_r[2:0])
      3'd0:    data_word = stream[79:64];
      3'd1:    data_word = stream[63:48];
      3'd2:    data_word = stream[47:32];
      3'd3:    data_word = stream[31:16];
      3'd4:    data_word = stream[15:0];
      default: data_word = '0;
    endcase
  end

  assign word_valid     = a_valid_r;
  assign word.line_word = (a_cmd_r == lsse_pkg::CMD_GAP) ? '0 : data_word;
  assign word.last_word = a_last;

  always_comb begin
    a_valid_nxt = a_valid_r;
    a_idx_nxt   = a_idx_r;
    if (take) begin
      a_valid_nxt = keep_item;
      a_idx_nxt   = '0;
    end else if (issue) begin
      a_valid_nxt = !a_last;
      a_idx_nxt   = a_idx_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      a_idx_r   <= '0;
    end else begin
      a_valid_r <= a_valid_nxt;
      a_idx_r   <= a_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_cmd_r  <= in_item.command;
      a_data_r <= in_item.data_byte;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/led_strip_symbol_encoder_core.sv]
// Top level of the LED strip symbol encoder: config, word generator and output register.
//
//   port group | direction | handshake        | payload
//   in_*       | input     | in_valid/in_stall | lsse_pkg::in_item_t (command, data_byte)
//   out_*      | output    | out_valid/out_stall | lsse_pkg::out_item_t (line_word, last_word)
//   cfg_*      | input     | cfg_we            | cfg_index, cfg_wdata
//
// One word leaves per cycle while out is not stalled: a data byte gives 5 words,
// a gap command min(gap_words, MAX_GAP_WORDS); a gap of zero words is accepted but gives none.
// The output port sets the rate; the next item is taken in the cycle its predecessor's last
// word moves into the output register. Words pass the item register, then the output register.
// Reset clears the item and output valid bits and loads the register reset values.
// A stall on out holds the output register and back-pressures in.
`default_nettype none

module led_strip_symbol_encoder_core #(
  parameter int unsigned MAX_GAP_WORDS = lsse_pkg::MAX_GAP_WORDS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire lsse_pkg::in_item_t                in_item,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output lsse_pkg::out_item_t                    out_item,
  input  wire logic                              cfg_we,
  input  wire logic [lsse_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [lsse_pkg::SYMBOL_BITS-1:0]  cfg_wdata
);

  lsse_pkg::cfg_t      cfg;
  lsse_pkg::out_item_t word;
  logic                word_valid;
  logic                load_en;

  logic                out_valid_r, out_valid_nxt;
  lsse_pkg::out_item_t out_item_r;

  lsse_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lsse_word_gen #(
    .MAX_GAP_WORDS (MAX_GAP_WORDS)
  ) u_gen (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .in_stall   (in_stall),
    .load_en    (load_en),
    .word_valid (word_valid),
    .word       (word)
  );

  assign load_en = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_en) begin
      out_valid_nxt = word_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en && word_valid) begin
      out_item_r <= word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_issue_lands: assert property (@(posedge clk) disable iff (!rst_n)
    word_valid && load_en |=> out_valid_r)
    else $error("issued word not captured in output register");

  a_data_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_item.command == lsse_pkg::CMD_DATA) |=> word_valid)
    else $error("accepted data item produced no word");

  a_rest_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_item_r.last_word |-> word_valid)
    else $error("item words lost before its last word");

endmodule

`default_nettype wire
